// ===== hdl/hll_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the HyperLogLog sketch store.
// Depends on nothing; every other file imports it.
package hll_pkg;

	localparam int PREC_MAX      = 14;
	localparam int MIN_PREC      = 4;
	localparam int STORE_DEPTH   = 1 << PREC_MAX;
	localparam int FULL_BITS     = 64;
	localparam int RANK_BASE     = 65;
	localparam int ADDR_W        = PREC_MAX;
	localparam int RANK_W        = 6;
	localparam int PREC_W        = $clog2(PREC_MAX + 1);
	localparam int CNT_W         = 64;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [PREC_W-1:0] prec_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Operation codes; codes five to seven are unused and give an OK result with no other effect.
	typedef enum logic [2:0] {
		OP_VALUE = 3'd0,
		OP_NULL  = 3'd1,
		OP_MERGE = 3'd2,
		OP_READ  = 3'd3,
		OP_CLEAR = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_RANGE    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SK_CLEAR,
		SK_IDLE,
		SK_EXEC
	} state_t;

	// Control for the rank unit: load captures a digest at the transfer.
	typedef struct packed {
		logic  load;
		prec_t prec;
	} rank_ctl_t;

	// One read port and one write port on the rank store.
	typedef struct packed {
		logic  rd_en;
		addr_t rd_addr;
		logic  wr_en;
		addr_t wr_addr;
		rank_t wr_data;
	} mem_req_t;

	// Precision register saturated into the supported range.
	function automatic prec_t eff_prec(input prec_t raw);
		prec_t p;
		p = raw;
		if (p < prec_t'(MIN_PREC))
			p = prec_t'(MIN_PREC);
		if (p > prec_t'(PREC_MAX))
			p = prec_t'(PREC_MAX);
		return p;
	endfunction

	// Largest rank a register may hold at precision p.
	function automatic rank_t rank_cap(input prec_t p);
		return rank_t'(RANK_BASE - int'(p));
	endfunction

endpackage

// ===== hdl/hyperloglog_sketch_update.sv =====
`timescale 1ns / 1ps
// HyperLogLog sketch store top level: command sequencer, counters, store and rank unit.
// Depends on hll_pkg, hll_store and hll_rank.
//
// Usage:
//   A command transfers at a rising edge with start high and busy low. The opcode picks
//   observe value, observe null, merge, read or clear; digest, reg_index and merge_rank
//   go with it. Each command gives exactly one result, shown for a single cycle while
//   done is high; the receiver cannot stall, so it must take the result in that cycle.
//   A command is executed in the cycle after its transfer, and its result is on the
//   outputs in the cycle after that. busy is high for that one execute cycle, so a new
//   command cannot transfer until the last one has executed; the limit is the
//   read-modify-write of the store (read issued at the transfer, write back in the
//   execute cycle). Because the next read is only issued after the write back, no
//   forwarding is needed. Clear walks the store one entry per cycle after its execute
//   cycle, over all 16384 entries, and its result is shown after the last entry.
//   Reset zeroes the counters and sets precision to 14, then runs the same clearing pass
//   over all 16384 entries with busy high; it gives no result. Precision writes on the
//   configuration channel are always ready and should be made while no command is open.
module hyperloglog_sketch_update import hll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [63:0] digest,
	input  logic [13:0] reg_index,
	input  logic [5:0]  merge_rank,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  precision,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  register_rank,
	output logic [63:0] input_total,
	output logic [63:0] value_total,
	output logic [63:0] null_total
);

	state_t   state_q, state_d;
	prec_t    prec_q;
	addr_t    clr_addr_q;
	logic     clr_emit_q;
	logic     clr_last;
	opcode_t  op_s1;
	addr_t    idx_s1;
	rank_t    mrank_s1;
	prec_t    p_s1;
	cnt_t     inputs_q, values_q, nulls_q;
	logic     done_q;
	status_t  status_q;
	rank_t    rank_q;

	logic      accept;
	prec_t     p_now;
	addr_t     digest_idx;
	mem_req_t  mem_req;
	rank_ctl_t rank_ctl;
	rank_t     rd_data;
	rank_t     obs_rank;

	status_t  st_d;
	rank_t    rk_d;
	logic     wr_d;
	rank_t    wr_data_d;
	logic     bump_val, bump_null;
	logic     idx_bad;
	rank_t    cap;

	assign busy      = (state_q != SK_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign p_now     = eff_prec(prec_q);
	assign clr_last  = (clr_addr_q == addr_t'(STORE_DEPTH - 1));

	// Register index from the top bits of the digest.
	assign digest_idx = addr_t'(digest[FULL_BITS-1 -: ADDR_W] >> (prec_t'(PREC_MAX) - p_now));

	assign rank_ctl = '{load: accept, prec: p_now};

	hll_rank u_rank (
		.clk    (clk),
		.ctl    (rank_ctl),
		.digest (digest),
		.rank   (obs_rank)
	);

	hll_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Capture the command at its transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode_t'(opcode);
			idx_s1   <= (opcode_t'(opcode) == OP_VALUE) ? digest_idx : addr_t'(reg_index);
			mrank_s1 <= rank_t'(merge_rank);
			p_s1     <= p_now;
		end
	end

	// Execute: decide status, shown rank, write back and counter updates.
	always_comb begin
		st_d      = STAT_OK;
		rk_d      = '0;
		wr_d      = 1'b0;
		wr_data_d = rd_data;
		bump_val  = 1'b0;
		bump_null = 1'b0;
		cap       = rank_cap(p_s1);
		idx_bad   = ((idx_s1 >> p_s1) != '0);
		unique case (op_s1)
			OP_VALUE: begin
				if ((&inputs_q) || (&values_q)) begin
					st_d = STAT_OVERFLOW;
					rk_d = rd_data;
				end else begin
					bump_val = 1'b1;
					if (obs_rank > rd_data) begin
						wr_d      = 1'b1;
						wr_data_d = obs_rank;
						rk_d      = obs_rank;
					end else begin
						rk_d = rd_data;
					end
				end
			end
			OP_NULL: begin
				if ((&inputs_q) || (&nulls_q))
					st_d = STAT_OVERFLOW;
				else
					bump_null = 1'b1;
			end
			OP_MERGE: begin
				if (idx_bad || (mrank_s1 > cap)) begin
					st_d = STAT_RANGE;
				end else if (mrank_s1 > rd_data) begin
					wr_d      = 1'b1;
					wr_data_d = mrank_s1;
					rk_d      = mrank_s1;
				end else begin
					rk_d = rd_data;
				end
			end
			OP_READ: begin
				if (idx_bad)
					st_d = STAT_RANGE;
				else
					rk_d = rd_data;
			end
			default: begin
				st_d = STAT_OK;
			end
		endcase
	end

	// Sequencer: next state and store access.
	always_comb begin
		state_d         = state_q;
		mem_req.rd_en   = accept;
		mem_req.rd_addr = (opcode_t'(opcode) == OP_VALUE) ? digest_idx : addr_t'(reg_index);
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = idx_s1;
		mem_req.wr_data = wr_data_d;
		unique case (state_q)
			SK_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = clr_addr_q;
				mem_req.wr_data = '0;
				if (clr_last)
					state_d = SK_IDLE;
			end
			SK_IDLE: begin
				if (accept)
					state_d = SK_EXEC;
			end
			SK_EXEC: begin
				mem_req.wr_en = wr_d;
				if (op_s1 == OP_CLEAR)
					state_d = SK_CLEAR;
				else
					state_d = SK_IDLE;
			end
			default: begin
				state_d = SK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SK_CLEAR;
		else
			state_q <= state_d;
	end

	// Precision register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prec_q <= prec_t'(PREC_MAX);
		else if (cfg_valid && cfg_ready)
			prec_q <= prec_t'(precision);
	end

	// Clearing pass address and the flag that a clear command awaits its result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_emit_q <= 1'b0;
		end else begin
			if (state_q == SK_CLEAR)
				clr_addr_q <= clr_addr_q + addr_t'(1);
			if (state_q == SK_EXEC && op_s1 == OP_CLEAR)
				clr_emit_q <= 1'b1;
			else if (state_q == SK_CLEAR && clr_last)
				clr_emit_q <= 1'b0;
		end
	end

	// Counters: bumped by accepted observations, zeroed by clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inputs_q <= '0;
			values_q <= '0;
			nulls_q  <= '0;
		end else if (state_q == SK_EXEC) begin
			if (op_s1 == OP_CLEAR) begin
				inputs_q <= '0;
				values_q <= '0;
				nulls_q  <= '0;
			end else begin
				if (bump_val || bump_null)
					inputs_q <= inputs_q + cnt_t'(1);
				if (bump_val)
					values_q <= values_q + cnt_t'(1);
				if (bump_null)
					nulls_q <= nulls_q + cnt_t'(1);
			end
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == SK_EXEC && op_s1 != OP_CLEAR) ||
				(state_q == SK_CLEAR && clr_last && clr_emit_q);
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (state_q == SK_EXEC) begin
			status_q <= st_d;
			rank_q   <= rk_d;
		end else if (state_q == SK_CLEAR && clr_last) begin
			status_q <= STAT_OK;
			rank_q   <= '0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign register_rank = rank_q;
	assign input_total   = inputs_q;
	assign value_total   = values_q;
	assign null_total    = nulls_q;

endmodule

// ===== hdl/hll_store.sv =====
`timescale 1ns / 1ps
// Rank register store: one write port, one read port with registered data.
// Depends on hll_pkg for the address, rank and request types.
module hll_store import hll_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output rank_t    rd_data
);

	rank_t mem [STORE_DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== hdl/hll_rank.sv =====
`timescale 1ns / 1ps
// Rank unit: leading-zero count of the digest bits below the index, plus one, capped.
// Two steps: per-byte counts registered at the transfer, then a byte priority pick.
// Depends on hll_pkg.
module hll_rank import hll_pkg::*; (
	input  logic      clk,
	input  rank_ctl_t ctl,
	input  cnt_t      digest,
	output rank_t     rank
);

	localparam int GROUPS = FULL_BITS / 8;

	logic [GROUPS-1:0] nz_d;
	logic [2:0]        lz_d [GROUPS];
	logic [GROUPS-1:0] nz_s1;
	logic [2:0]        lz_s1 [GROUPS];
	prec_t             prec_s1;
	cnt_t              rest;
	logic [6:0]        lz_all;
	logic [6:0]        rank_full;
	logic [6:0]        cap;

	// Leading zeros of a nonzero byte.
	function automatic logic [2:0] lzc8(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd7;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				n = 3'(7 - i);
		end
		return n;
	endfunction

	// First step: drop the index bits and count zeros within each byte.
	always_comb begin
		rest = digest << ctl.prec;
		for (int g = 0; g < GROUPS; g++) begin
			nz_d[g] = |rest[FULL_BITS-1-8*g -: 8];
			lz_d[g] = lzc8(rest[FULL_BITS-1-8*g -: 8]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			nz_s1   <= nz_d;
			lz_s1   <= lz_d;
			prec_s1 <= ctl.prec;
		end
	end

	// Second step: the most significant nonzero byte decides; all zero counts 64.
	always_comb begin
		lz_all = 7'(FULL_BITS);
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (nz_s1[g])
				lz_all = 7'(8 * g) + 7'(lz_s1[g]);
		end
		rank_full = lz_all + 7'd1;
		cap       = {1'b0, rank_cap(prec_s1)};
		rank      = (rank_full > cap) ? cap[RANK_W-1:0] : rank_full[RANK_W-1:0];
	end

endmodule

// ===== hdl/hll_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the HyperLogLog sketch store, bound to the top level.
// Depends on hll_pkg and hyperloglog_sketch_update.
module hll_checker import hll_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  opcode,
	input logic        done,
	input logic [1:0]  status,
	input logic [5:0]  register_rank,
	input logic [63:0] input_total
);

	// Every command other than clear is followed by its result strobe; clear waits on the clearing pass.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != OP_CLEAR) |-> ##2 done)
		else $error("result missing two cycles after a command transfer");

	// Results are single-cycle strobes.
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A rejected merge or read shows no rank.
	a_range_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_RANGE) |-> (register_rank == '0))
		else $error("out-of-range result shows a nonzero rank");

	// A skipped observation leaves the input count alone.
	a_skip_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_OVERFLOW) |-> (input_total == $past(input_total)))
		else $error("skipped observation changed the input count");

	// Status never takes the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STAT_OK || status == STAT_OVERFLOW || status == STAT_RANGE))
		else $error("unused status code shown");

endmodule

bind hyperloglog_sketch_update hll_checker u_hll_checker (.*);
